// ===== src/firlt_pkg.sv =====
package firlt_pkg;

    // width of the taps-in-use register and of the coefficient index field
    localparam int CFG_BITS      = 7;
    localparam int COEF_IDX_BITS = 6;

    localparam logic [CFG_BITS-1:0] TAPS_RESET = 7'd63;

    // item kinds carried on the input tuser bit
    localparam logic OP_LOAD   = 1'b0;
    localparam logic OP_SAMPLE = 1'b1;

    // commands from the controller to the datapath
    typedef struct packed {
        logic coef_wr;    // write one tap weight
        logic smp_shift;  // shift a new sample into the delay line
        logic acc_clr;    // clear the accumulator
        logic issue;      // one mac step: read tap, rotate delay line
        logic use_tap;    // this step lies inside the taps in use
        logic fin_load;   // round, saturate and load the output register
    } t_dp_cmd;

    // status from the datapath to the controller
    typedef struct packed {
        logic out_free;   // output register can take a new result
    } t_dp_sts;

endpackage

// ===== src/firlt_ctrl.sv =====
module firlt_ctrl #(
    parameter int MAX_TAPS = 64
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    input  logic                           i_in_op,
    output logic                           o_in_ready,
    input  logic                           i_cfg_wr_en,
    input  logic [firlt_pkg::CFG_BITS-1:0] i_cfg_wr_data,
    input  firlt_pkg::t_dp_sts             i_sts,
    output firlt_pkg::t_dp_cmd             o_cmd,
    output logic [$clog2(MAX_TAPS)-1:0]    o_step_addr
);
    import firlt_pkg::*;

    localparam int IDX_W = $clog2(MAX_TAPS);
    localparam int CMP_W = (IDX_W > CFG_BITS) ? IDX_W : CFG_BITS;
    localparam logic [IDX_W-1:0] LAST_STEP = IDX_W'(MAX_TAPS - 1);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RUN,
        ST_DRAIN1,
        ST_DRAIN2,
        ST_FIN
    } t_state;

    t_state               r_state, n_state;
    logic [IDX_W-1:0]     r_step, n_step;
    logic [CFG_BITS-1:0]  r_taps_in_use;
    logic                 w_accept;

    assign o_in_ready  = (r_state == ST_IDLE) && i_rst_n;
    assign w_accept    = i_in_valid && o_in_ready;
    assign o_step_addr = r_step;

    always_comb begin
        n_state = r_state;
        n_step  = r_step;
        o_cmd   = '0;
        unique case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    if (i_in_op == OP_SAMPLE) begin
                        o_cmd.smp_shift = 1'b1;
                        o_cmd.acc_clr   = 1'b1;
                        n_step          = '0;
                        n_state         = ST_RUN;
                    end else begin
                        o_cmd.coef_wr = 1'b1;
                    end
                end
            end
            ST_RUN: begin
                o_cmd.issue   = 1'b1;
                // step index is always below the store depth, so this also caps at it
                o_cmd.use_tap = CMP_W'(r_step) < CMP_W'(r_taps_in_use);
                if (r_step == LAST_STEP) begin
                    n_state = ST_DRAIN1;
                end else begin
                    n_step = r_step + 1'b1;
                end
            end
            ST_DRAIN1: n_state = ST_DRAIN2;
            ST_DRAIN2: n_state = ST_FIN;
            ST_FIN: begin
                if (i_sts.out_free) begin
                    o_cmd.fin_load = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= ST_IDLE;
            r_step        <= '0;
            r_taps_in_use <= TAPS_RESET;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
            if (i_cfg_wr_en) begin
                r_taps_in_use <= i_cfg_wr_data;
            end
        end
    end

endmodule

// ===== src/firlt_dp.sv =====
module firlt_dp #(
    parameter int MAX_TAPS    = 64,
    parameter int SAMPLE_BITS = 16,
    parameter int COEF_BITS   = 18
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  firlt_pkg::t_dp_cmd                  i_cmd,
    input  logic [$clog2(MAX_TAPS)-1:0]         i_step_addr,
    input  logic [firlt_pkg::COEF_IDX_BITS-1:0] i_coef_index,
    input  logic signed [COEF_BITS-1:0]         i_coef_value,
    input  logic signed [SAMPLE_BITS-1:0]       i_sample,
    input  logic                                i_out_ready,
    output firlt_pkg::t_dp_sts                  o_sts,
    output logic                                o_out_valid,
    output logic signed [SAMPLE_BITS-1:0]       o_filtered,
    output logic                                o_saturated
);
    import firlt_pkg::*;

    localparam int IDX_W  = $clog2(MAX_TAPS);
    localparam int PROD_W = COEF_BITS + SAMPLE_BITS;
    localparam int ACC_W  = PROD_W + IDX_W;
    localparam int FRAC   = COEF_BITS - 1;

    localparam logic signed [ACC_W:0] HALF   = (ACC_W+1)'(1) << (FRAC - 1);
    localparam logic signed [ACC_W:0] SAT_HI = (ACC_W+1)'((1 << (SAMPLE_BITS - 1)) - 1);
    localparam logic signed [ACC_W:0] SAT_LO = -SAT_HI - 1;
    localparam logic signed [SAMPLE_BITS-1:0] OUT_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    localparam logic signed [SAMPLE_BITS-1:0] OUT_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

    // tap store with per-entry valid bits, unwritten entries read as zero
    logic [COEF_BITS-1:0]          r_tap_mem [MAX_TAPS];
    logic [MAX_TAPS-1:0]           r_tap_vld;
    logic signed [SAMPLE_BITS-1:0] r_dly [MAX_TAPS];

    logic signed [COEF_BITS-1:0]   r_tap_q;
    logic signed [SAMPLE_BITS-1:0] r_smp_q;
    logic                          r_s1_v, r_s1_ok, r_s2_v;
    logic signed [PROD_W-1:0]      r_prod;
    logic signed [ACC_W-1:0]       r_acc;

    logic                          r_out_vld, r_out_sat;
    logic signed [SAMPLE_BITS-1:0] r_out_filt;

    logic                          w_wr_ok;
    logic [IDX_W-1:0]              w_wr_addr;
    logic signed [ACC_W:0]         w_acc_x, w_rnd, w_q;
    logic                          w_hi, w_lo;

    assign w_wr_ok   = i_cmd.coef_wr && (int'(i_coef_index) < MAX_TAPS);
    assign w_wr_addr = IDX_W'(i_coef_index);

    always_ff @(posedge i_clk) begin
        if (w_wr_ok) begin
            r_tap_mem[w_wr_addr] <= i_coef_value;
        end
        if (i_cmd.issue) begin
            r_tap_q <= r_tap_mem[i_step_addr];
            r_smp_q <= r_dly[0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tap_vld <= '0;
        end else if (w_wr_ok) begin
            r_tap_vld[w_wr_addr] <= 1'b1;
        end
    end

    // delay line: shift on a new sample, rotate one place per mac step so
    // that the tap being worked sits at position 0 and a full pass realigns
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < MAX_TAPS; i++) begin
                r_dly[i] <= '0;
            end
        end else if (i_cmd.smp_shift) begin
            r_dly[0] <= i_sample;
            for (int i = 1; i < MAX_TAPS; i++) begin
                r_dly[i] <= r_dly[i-1];
            end
        end else if (i_cmd.issue) begin
            for (int i = 0; i < MAX_TAPS - 1; i++) begin
                r_dly[i] <= r_dly[i+1];
            end
            r_dly[MAX_TAPS-1] <= r_dly[0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v  <= 1'b0;
            r_s1_ok <= 1'b0;
            r_s2_v  <= 1'b0;
        end else begin
            r_s1_v  <= i_cmd.issue;
            r_s1_ok <= i_cmd.issue && i_cmd.use_tap && r_tap_vld[i_step_addr];
            r_s2_v  <= r_s1_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_s1_ok) begin
            r_prod <= r_tap_q * r_smp_q;
        end else begin
            r_prod <= '0;
        end
        if (i_cmd.acc_clr) begin
            r_acc <= '0;
        end else if (r_s2_v) begin
            r_acc <= r_acc + ACC_W'(r_prod);
        end
    end

    // round half up, drop the fraction, clip to the sample range
    assign w_acc_x = (ACC_W+1)'(r_acc);
    assign w_rnd   = w_acc_x + HALF;
    assign w_q     = w_rnd >>> FRAC;
    assign w_hi    = w_q > SAT_HI;
    assign w_lo    = w_q < SAT_LO;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (i_cmd.fin_load) begin
            r_out_vld <= 1'b1;
        end else if (i_out_ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.fin_load) begin
            r_out_sat  <= w_hi || w_lo;
            r_out_filt <= w_hi ? OUT_MAX : (w_lo ? OUT_MIN : w_q[SAMPLE_BITS-1:0]);
        end
    end

    assign o_sts.out_free = !r_out_vld || i_out_ready;
    assign o_out_valid    = r_out_vld;
    assign o_filtered     = r_out_filt;
    assign o_saturated    = r_out_sat;

endmodule

// ===== src/fir_filter_loadable_taps.sv =====
// channel   | direction | signals        | beat contents
// ----------+-----------+----------------+---------------------------------------------
// s_axis    | in        | tvalid/tready  | tuser: op; tdata: coef_index, coef_value,
//           |           |                | sample (lowest bits first)
// m_axis    | out       | tvalid/tready  | tuser: saturated; tdata: filtered
// cfg       | in        | wr_en/wr_data  | taps_in_use, written on any edge with wr_en
//
// a coefficient-load beat leaves the block idle, ready for the next beat, and gives no result
// a sample beat holds off the next beat while one shared multiply-accumulate
// walks every tap slot of the store, then through the two pipeline drain states
// and the rounding state, which waits for the output register to be free
// reset is synchronous; it clears the delay line, the tap valid bits and sets
// taps_in_use to 63
// a result waiting in the output register does not block the next beat; only
// the rounding step waits for it to be taken
module fir_filter_loadable_taps #(
    parameter int MAX_TAPS    = 64,
    parameter int SAMPLE_BITS = 16,
    parameter int COEF_BITS   = 18
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    // coef_index [5:0], coef_value, sample, zero padding to whole bytes
    input  logic [((firlt_pkg::COEF_IDX_BITS + COEF_BITS + SAMPLE_BITS + 7) / 8) * 8 - 1:0]
                                           s_axis_tdata,
    // op (0 = load coefficient, 1 = filter sample)
    input  logic                           s_axis_tuser,
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    // filtered, zero padding to whole bytes
    output logic [((SAMPLE_BITS + 7) / 8) * 8 - 1:0] m_axis_tdata,
    // saturated
    output logic                           m_axis_tuser,
    input  logic                           i_cfg_wr_en,
    input  logic [firlt_pkg::CFG_BITS-1:0] i_cfg_wr_data
);
    import firlt_pkg::*;

    localparam int IDX_W    = $clog2(MAX_TAPS);
    localparam int OUT_W    = ((SAMPLE_BITS + 7) / 8) * 8;
    localparam int COEF_LSB = COEF_IDX_BITS;
    localparam int SMP_LSB  = COEF_IDX_BITS + COEF_BITS;

    t_dp_cmd                       w_cmd;
    t_dp_sts                       w_sts;
    logic [IDX_W-1:0]              w_step_addr;
    logic [COEF_IDX_BITS-1:0]      w_coef_index;
    logic signed [COEF_BITS-1:0]   w_coef_value;
    logic signed [SAMPLE_BITS-1:0] w_sample;
    logic [SAMPLE_BITS-1:0]        w_filtered;

    // unpack the input beat
    assign w_coef_index = s_axis_tdata[COEF_IDX_BITS-1:0];
    assign w_coef_value = s_axis_tdata[COEF_LSB +: COEF_BITS];
    assign w_sample     = s_axis_tdata[SMP_LSB +: SAMPLE_BITS];

    firlt_ctrl #(
        .MAX_TAPS (MAX_TAPS)
    ) u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (s_axis_tvalid),
        .i_in_op       (s_axis_tuser),
        .o_in_ready    (s_axis_tready),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_sts         (w_sts),
        .o_cmd         (w_cmd),
        .o_step_addr   (w_step_addr)
    );

    firlt_dp #(
        .MAX_TAPS    (MAX_TAPS),
        .SAMPLE_BITS (SAMPLE_BITS),
        .COEF_BITS   (COEF_BITS)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (w_cmd),
        .i_step_addr  (w_step_addr),
        .i_coef_index (w_coef_index),
        .i_coef_value (w_coef_value),
        .i_sample     (w_sample),
        .i_out_ready  (m_axis_tready),
        .o_sts        (w_sts),
        .o_out_valid  (m_axis_tvalid),
        .o_filtered   (w_filtered),
        .o_saturated  (m_axis_tuser)
    );

    // pack the result beat, upper bits zero
    assign m_axis_tdata = OUT_W'(w_filtered);

endmodule

// ===== bench/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;

    localparam int MAX_TAPS    = 64;
    localparam int SAMPLE_BITS = 16;
    localparam int COEF_BITS   = 18;
    localparam int FRAC_BITS   = COEF_BITS - 1;
    localparam int DATA_BITS   = firlt_pkg::COEF_IDX_BITS + COEF_BITS + SAMPLE_BITS;
    // one sample beat walks every tap slot, plus drain and rounding, plus margin
    localparam int SETTLE_CYCLES = MAX_TAPS + 36;
    localparam int STALL_LIMIT   = 5000;
    localparam int RANDOM_BEATS  = 176;

    // one beat on the input side
    typedef struct {
        logic                             op;
        logic [firlt_pkg::COEF_IDX_BITS-1:0] coef_index;
        logic signed [COEF_BITS-1:0]      coef_value;
        logic signed [SAMPLE_BITS-1:0]    sample;
    } fir_beat_t;

    // one beat on the output side
    typedef struct {
        logic signed [SAMPLE_BITS-1:0] filtered;
        logic                          saturated;
    } fir_result_t;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    logic                     s_axis_tvalid = 1'b0;
    logic                     s_axis_tready;
    // coef_index [5:0], coef_value [23:6], sample [39:24]
    logic [DATA_BITS-1:0]     s_axis_tdata  = '0;
    // op
    logic                     s_axis_tuser  = firlt_pkg::OP_LOAD;
    logic                     m_axis_tvalid;
    logic                     m_axis_tready = 1'b0;
    // filtered [15:0]
    logic [SAMPLE_BITS-1:0]   m_axis_tdata;
    // saturated
    logic                     m_axis_tuser;
    logic                     i_cfg_wr_en   = 1'b0;
    logic [firlt_pkg::CFG_BITS-1:0] i_cfg_wr_data = '0;

    fir_filter_loadable_taps i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data)
    );

    // beats waiting to be driven, and filter outputs still owed by the block
    fir_beat_t   beats_to_send[$];
    fir_result_t predicted_outputs[$];

    // shadow of the block state: tap store, delay line, taps in use
    logic signed [COEF_BITS-1:0]   tap_copy [MAX_TAPS];
    logic signed [SAMPLE_BITS-1:0] history  [MAX_TAPS];
    logic [firlt_pkg::CFG_BITS-1:0] taps_setting = firlt_pkg::TAPS_RESET;

    // idle percentages for both sides, changed between phases
    int send_idle_pct = 21;
    int recv_idle_pct = 83;

    int failures     = 0;
    int n_loads      = 0;
    int n_samples    = 0;
    int n_clipped    = 0;
    int n_settings   = 0;
    int stall_cycles = 0;

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        for (int k = 0; k < MAX_TAPS; k++) begin
            tap_copy[k] = '0;
            history[k]  = '0;
        end
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
    end

    // shift a sample into the shadow delay line and work out the filter output
    function automatic fir_result_t filter_sample(input logic signed [SAMPLE_BITS-1:0] smp);
        longint      acc;
        longint      q;
        int          count;
        fir_result_t res;
        for (int k = MAX_TAPS - 1; k > 0; k--)
            history[k] = history[k-1];
        history[0] = smp;
        // settings above the store size use every tap
        count = (taps_setting > MAX_TAPS) ? MAX_TAPS : int'(taps_setting);
        acc = 0;
        for (int k = 0; k < count; k++)
            acc += longint'(tap_copy[k]) * longint'(history[k]);
        // round half up, then drop the fraction bits
        q = (acc + (longint'(1) <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
        res.saturated = 1'b0;
        if (q > 32767) begin
            q = 32767;
            res.saturated = 1'b1;
        end else if (q < -32768) begin
            q = -32768;
            res.saturated = 1'b1;
        end
        res.filtered = q[SAMPLE_BITS-1:0];
        return res;
    endfunction

    function automatic fir_beat_t load_beat(input int idx, input int value);
        fir_beat_t b;
        b.op         = firlt_pkg::OP_LOAD;
        b.coef_index = idx[firlt_pkg::COEF_IDX_BITS-1:0];
        b.coef_value = value[COEF_BITS-1:0];
        b.sample     = SAMPLE_BITS'($urandom);
        return b;
    endfunction

    function automatic fir_beat_t sample_beat(input int value);
        fir_beat_t   b;
        int unsigned rnd;
        rnd          = $urandom;
        b.op         = firlt_pkg::OP_SAMPLE;
        b.coef_index = rnd[firlt_pkg::COEF_IDX_BITS-1:0];
        b.coef_value = COEF_BITS'($urandom);
        b.sample     = value[SAMPLE_BITS-1:0];
        return b;
    endfunction

    // random beat: tap weights and samples from full range, small range and extremes
    function automatic fir_beat_t random_beat();
        int cv;
        int sv;
        case ($urandom_range(3))
            0: cv = $urandom;
            1: cv = int'($urandom_range(4095)) - 2048;
            2: cv = ($urandom_range(1) != 0) ? 131071 : -131072;
            default: cv = int'($urandom_range(262143)) - 131072 >>> $urandom_range(14);
        endcase
        case ($urandom_range(3))
            0: sv = ($urandom_range(1) != 0) ? 32767 : -32768;
            1: sv = int'($urandom_range(511)) - 256;
            default: sv = $urandom;
        endcase
        if ($urandom_range(99) < 40)
            return load_beat($urandom_range(MAX_TAPS - 1), cv);
        return sample_beat(sv);
    endfunction

    // driver: hold the beat until taken, predict at the accepting edge
    always @(posedge i_clk) begin
        fir_beat_t   nb;
        fir_result_t r;
        logic        taken;
        logic        next_valid;
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            taken = s_axis_tvalid && s_axis_tready;
            if (taken) begin
                if (s_axis_tuser == firlt_pkg::OP_LOAD) begin
                    tap_copy[s_axis_tdata[5:0]] = s_axis_tdata[23:6];
                    n_loads++;
                end else begin
                    r = filter_sample(s_axis_tdata[39:24]);
                    predicted_outputs.push_back(r);
                    n_samples++;
                end
            end
            next_valid = s_axis_tvalid && !taken;
            // a new beat only once the previous one has gone
            if (!next_valid && beats_to_send.size() != 0
                    && $urandom_range(99) >= send_idle_pct) begin
                nb = beats_to_send.pop_front();
                s_axis_tdata <= {nb.sample, nb.coef_value, nb.coef_index};
                s_axis_tuser <= nb.op;
                next_valid = 1'b1;
            end
            s_axis_tvalid <= next_valid;
        end
    end

    // monitor: compare each output beat with the oldest prediction
    always @(posedge i_clk) begin
        fir_result_t want;
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (predicted_outputs.size() == 0) begin
                    $error("output beat with nothing expected: filtered %0d saturated %0d",
                           $signed(m_axis_tdata), m_axis_tuser);
                    failures++;
                end else begin
                    want = predicted_outputs.pop_front();
                    if (want.saturated)
                        n_clipped++;
                    if (m_axis_tdata !== want.filtered) begin
                        $error("filtered: expected %0d, got %0d",
                               want.filtered, $signed(m_axis_tdata));
                        failures++;
                    end
                    if (m_axis_tuser !== want.saturated) begin
                        $error("saturated: expected %0d, got %0d",
                               want.saturated, m_axis_tuser);
                        failures++;
                    end
                end
            end
            m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // watchdog: too long without any beat or register write means a hang
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
                    || i_cfg_wr_en)
                stall_cycles <= 0;
            else
                stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= STALL_LIMIT) begin
                $display("timeout after %0d cycles without progress", STALL_LIMIT);
                $display("fir_filter_loadable_taps test failed");
                $finish;
            end
        end
    end

    // nothing queued, nothing on the bus and no output still owed
    task automatic wait_drained();
        @(negedge i_clk);
        while (beats_to_send.size() != 0 || s_axis_tvalid || predicted_outputs.size() != 0)
            @(negedge i_clk);
    endtask

    // register write only once the block has gone quiet
    task automatic write_taps(input int value);
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= value[firlt_pkg::CFG_BITS-1:0];
        @(posedge i_clk);
        i_cfg_wr_en   <= 1'b0;
        taps_setting = value[firlt_pkg::CFG_BITS-1:0];
        n_settings++;
    endtask

    // random phase with a full drain in the middle, so the sender waits on the block
    task automatic send_random(input int count);
        for (int i = 0; i < count / 2; i++)
            beats_to_send.push_back(random_beat());
        wait_drained();
        for (int i = count / 2; i < count; i++)
            beats_to_send.push_back(random_beat());
        wait_drained();
    endtask

    initial begin
        int settings [7];
        settings = '{64, 1, 0, 127, 0, 0, 63};
        settings[4] = $urandom_range(62, 2);
        settings[5] = $urandom_range(126, 65);

        while (!i_rst_n) @(posedge i_clk);
        @(negedge i_clk);

        // directed part, reset taps setting of 63 so the top slot is ignored
        beats_to_send.push_back(sample_beat(1));          // all weights zero
        beats_to_send.push_back(load_beat(0, 65536));     // one half
        beats_to_send.push_back(sample_beat(1));          // tie rounds up to 1
        beats_to_send.push_back(sample_beat(-1));         // tie rounds up to 0
        beats_to_send.push_back(load_beat(0, -131072));   // minus one
        beats_to_send.push_back(sample_beat(-32768));     // positive clip
        beats_to_send.push_back(sample_beat(32767));
        beats_to_send.push_back(load_beat(0, 131071));
        beats_to_send.push_back(load_beat(1, 131071));
        beats_to_send.push_back(sample_beat(32767));
        beats_to_send.push_back(sample_beat(32767));      // two near-unity taps clip high
        beats_to_send.push_back(sample_beat(-32768));
        beats_to_send.push_back(sample_beat(-32768));     // clip low
        beats_to_send.push_back(load_beat(63, -131072));  // outside the taps in use
        beats_to_send.push_back(load_beat(62, 131071));
        beats_to_send.push_back(sample_beat(0));
        beats_to_send.push_back(sample_beat(-32768));
        beats_to_send.push_back(load_beat(1, 0));
        beats_to_send.push_back(sample_beat(12345));
        wait_drained();

        // random phases over several tap settings and idling patterns
        for (int p = 0; p < 7; p++) begin
            if (p == 2) begin
                send_idle_pct = 83;
                recv_idle_pct = 21;
            end else if (p == 4) begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            write_taps(settings[p]);
            send_random(RANDOM_BEATS);
        end

        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        $display("covered %0d coefficient loads and %0d samples over %0d tap settings",
                 n_loads, n_samples, n_settings + 1);
        $display("%0d outputs clipped, %0d mismatches", n_clipped, failures);
        if (failures == 0)
            $display("fir_filter_loadable_taps test passed");
        else
            $display("fir_filter_loadable_taps test failed");
        $finish;
    end

endmodule

// ===== sim.f =====
src/firlt_pkg.sv
src/firlt_ctrl.sv
src/firlt_dp.sv
src/fir_filter_loadable_taps.sv
bench/tb_top.sv
